[hdl/fcs_pkg.sv]
// Shared constants and types for the streaming FIR convolution block.
// No dependencies; imported by every module of the block.
package fcs_pkg;

  localparam int TAPS        = 7;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int OUT_BITS    = 35;
  localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
  localparam int NUM_REGS    = 8;
  localparam int IDX_BITS    = 3;
  localparam int TCNT_BITS   = 3;
  localparam int NTAP_BITS   = $clog2(TAPS + 1);
  localparam int CNT_BITS    = $clog2(TAPS);
  localparam int PAIRS       = (TAPS + 1) / 2;

  // register map
  localparam logic [IDX_BITS-1:0] REG_TAP_COUNT = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_COEF_0    = 3'd1;

  localparam logic [TCNT_BITS-1:0] TAP_COUNT_RESET = 3'd7;

  typedef struct packed {
    logic load_pair;
    logic load_out;
  } sum_ctl_t;

endpackage

[hdl/fir_convolution_stream.sv]
// Streaming FIR convolution top level: config registers, tail sequencer,
// pipeline control. Depends on fcs_pkg, fcs_cell and fcs_sum.
//
// Usage:
//   Input channel (sample, seq_end, in_valid/in_ready) takes one sample per
//   item. Each sample yields one result (conv_value, run_last) on the output
//   channel (out_valid/out_ready). After the sample marked seq_end the block
//   issues tap_count-1 tail results (none for tap_count 0) on its own, one per
//   cycle unless the output stalls, holding in_ready low meanwhile; the final
//   result of the sequence has run_last set and the delay line is zeroed behind it.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready: index 0 is tap_count, 1..7 are coef_0..coef_6.
//   Pipeline: a result passes the product registers, loaded at the edge that
//   accepts its item, then the pair-sum stage, then the output register.
//   Throughput: one item per cycle while no stall or tail holds it, set by the
//   tap cells stepping once per cycle; a sequence end holds off input for its tail.
//   A stalled receiver holds the output register; stages behind it keep
//   filling until the pipeline is full, then in_ready drops.
//   Reset: tap_count 7, coef_0 = coef_6 = 1, others 0, delay line zero,
//   pipeline empty.
module fir_convolution_stream (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [fcs_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   seq_end,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [fcs_pkg::OUT_BITS-1:0]    conv_value,
  output logic                                   run_last,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [fcs_pkg::IDX_BITS-1:0]           cfg_index,
  input  logic [fcs_pkg::COEF_BITS-1:0]          cfg_data
);
  import fcs_pkg::*;

  logic [TCNT_BITS-1:0]        tap_count;
  logic signed [COEF_BITS-1:0] coef [TAPS];
  logic [NTAP_BITS-1:0]        taps;
  logic [CNT_BITS-1:0]         tail_cnt;
  logic [CNT_BITS-1:0]         tail_cnt_next;

  logic p_v, p_l, s_v, s_l, o_v, o_l;
  logic en_p, en_s, en_o;
  logic tailing, issue, take, issue_last;
  logic signed [SAMPLE_BITS-1:0] issue_sample;

  logic signed [SAMPLE_BITS-1:0] chain [TAPS+1];
  logic signed [PROD_BITS-1:0]   prod [TAPS];
  sum_ctl_t                      sum_ctl;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_RESET;
      for (int k = 0; k < TAPS; k++) begin
        coef[k] <= (k == 0 || k == TAPS - 1) ? COEF_BITS'(1) : '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TAP_COUNT) begin
        tap_count <= cfg_data[TCNT_BITS-1:0];
      end
      for (int k = 0; k < TAPS; k++) begin
        if (int'(cfg_index) == int'(REG_COEF_0) + k) begin
          coef[k] <= cfg_data;
        end
      end
    end
  end

  // zero counts as one tap, anything above the cell count is clamped
  always_comb begin
    if (tap_count == '0) begin
      taps = NTAP_BITS'(1);
    end else if (int'(tap_count) > TAPS) begin
      taps = NTAP_BITS'(TAPS);
    end else begin
      taps = NTAP_BITS'(tap_count);
    end
  end

  // pipeline control
  assign en_o = !o_v || out_ready;
  assign en_s = !s_v || en_o;
  assign en_p = !p_v || en_s;

  assign tailing      = (tail_cnt != '0);
  assign in_ready     = en_p && !tailing;
  assign take         = in_valid && in_ready;
  assign issue        = en_p && (tailing || in_valid);
  assign issue_sample = tailing ? '0 : sample;
  assign issue_last   = tailing ? (tail_cnt == CNT_BITS'(1))
                                : (seq_end && taps == NTAP_BITS'(1));

  always_comb begin
    tail_cnt_next = tail_cnt;
    if (issue && tailing) begin
      tail_cnt_next = tail_cnt - CNT_BITS'(1);
    end else if (take && seq_end && taps != NTAP_BITS'(1)) begin
      tail_cnt_next = CNT_BITS'(taps - NTAP_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_cnt <= '0;
      p_v      <= 1'b0;
      s_v      <= 1'b0;
      o_v      <= 1'b0;
    end else begin
      tail_cnt <= tail_cnt_next;
      if (en_p) begin
        p_v <= issue;
      end
      if (en_s) begin
        s_v <= p_v;
      end
      if (en_o) begin
        o_v <= s_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_p) begin
      p_l <= issue_last;
    end
    if (en_s) begin
      s_l <= p_l;
    end
    if (en_o) begin
      o_l <= s_l;
    end
  end

  // tap cells; the delay line clears behind the last item of a sequence
  assign chain[0] = issue_sample;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    fcs_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .step   (issue),
      .clear  (issue_last),
      .tap_on (int'(taps) > k),
      .coef   (coef[k]),
      .prev   (chain[k]),
      .held   (chain[k+1]),
      .prod   (prod[k])
    );
  end

  assign sum_ctl.load_pair = en_s;
  assign sum_ctl.load_out  = en_o;

  fcs_sum u_sum (
    .clk   (clk),
    .ctl   (sum_ctl),
    .prod  (prod),
    .total (conv_value)
  );

  assign out_valid = o_v;
  assign run_last  = o_l;

endmodule

[hdl/fcs_cell.sv]
// One tap cell: a delay line stage plus its registered product.
// Depends on fcs_pkg.
module fcs_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step,
  input  logic                                 clear,
  input  logic                                 tap_on,
  input  logic signed [fcs_pkg::COEF_BITS-1:0]   coef,
  input  logic signed [fcs_pkg::SAMPLE_BITS-1:0] prev,
  output logic signed [fcs_pkg::SAMPLE_BITS-1:0] held,
  output logic signed [fcs_pkg::PROD_BITS-1:0]   prod
);
  import fcs_pkg::*;

  // product uses the incoming value prev of the current step, even when clear zeroes held
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (step) begin
      held <= clear ? '0 : prev;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      prod <= tap_on ? PROD_BITS'(coef) * PROD_BITS'(prev) : '0;
    end
  end

endmodule

[hdl/fcs_sum.sv]
// Registered adder tree over the cell products: pair sums, then the output sum.
// Depends on fcs_pkg.
module fcs_sum (
  input  logic                                 clk,
  input  fcs_pkg::sum_ctl_t                    ctl,
  input  logic signed [fcs_pkg::PROD_BITS-1:0] prod [fcs_pkg::TAPS],
  output logic signed [fcs_pkg::OUT_BITS-1:0]  total
);
  import fcs_pkg::*;

  logic signed [OUT_BITS-1:0] pair [PAIRS];
  logic signed [OUT_BITS-1:0] total_next;

  for (genvar i = 0; i < PAIRS; i++) begin : g_pair
    if (2 * i + 1 < TAPS) begin : g_two
      always_ff @(posedge clk) begin
        if (ctl.load_pair) begin
          pair[i] <= OUT_BITS'(prod[2*i]) + OUT_BITS'(prod[2*i+1]);
        end
      end
    end else begin : g_one
      always_ff @(posedge clk) begin
        if (ctl.load_pair) begin
          pair[i] <= OUT_BITS'(prod[2*i]);
        end
      end
    end
  end

  always_comb begin
    total_next = '0;
    for (int i = 0; i < PAIRS; i++) begin
      total_next = total_next + pair[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      total <= total_next;
    end
  end

endmodule

[sim/tb_top.sv]
// Self-checking testbench for fir_convolution_stream: directed and random sample
// sequences, a shadow FIR predictor and a result scoreboard. Depends on fcs_pkg.
`timescale 1ns / 100ps

module tb_top;
  import fcs_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] value;
    logic                       last;
  } conv_result_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          seq_end;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [OUT_BITS-1:0]    conv_value;
  logic                          run_last;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [IDX_BITS-1:0]           cfg_index;
  logic [COEF_BITS-1:0]          cfg_data;

  // shadow copy of the block's registers and delay line
  logic [TCNT_BITS-1:0]          tap_cnt;
  logic signed [COEF_BITS-1:0]   coefs [TAPS];
  logic signed [SAMPLE_BITS-1:0] history [TAPS];

  conv_result_t expected_q[$];

  int fail_count;
  int items_sent;
  int results_checked;
  int seqs_sent;
  int cfg_writes;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int hold_ack;
  int hold_left;

  fir_convolution_stream dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .seq_end   (seq_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .conv_value(conv_value),
    .run_last  (run_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int active_taps();
    int n;
    n = int'(tap_cnt);
    if (n == 0) n = 1;
    if (n > TAPS) n = TAPS;
    return n;
  endfunction

  function automatic void shift_history(logic signed [SAMPLE_BITS-1:0] s);
    for (int i = TAPS - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = s;
  endfunction

  function automatic logic signed [OUT_BITS-1:0] fir_sum(int n);
    longint acc;
    acc = 0;
    for (int k = 0; k < n; k++) acc += longint'(coefs[k]) * longint'(history[k]);
    return acc[OUT_BITS-1:0];
  endfunction

  // one accepted sample -> its output plus, on a sequence end, the tail
  function automatic void predict_fir(logic signed [SAMPLE_BITS-1:0] s, logic e);
    int n;
    conv_result_t r;
    n = active_taps();
    shift_history(s);
    r.value = fir_sum(n);
    r.last  = e && (n == 1);
    expected_q.push_back(r);
    if (e) begin
      for (int k = 1; k < n; k++) begin
        shift_history('0);
        r.value = fir_sum(n);
        r.last  = (k == n - 1);
        expected_q.push_back(r);
      end
      for (int i = 0; i < TAPS; i++) history[i] = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    conv_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected item: conv_value=%0d run_last=%0b", conv_value, run_last);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (conv_value !== want.value) begin
          $error("conv_value mismatch: expected %0d, got %0d", want.value, conv_value);
          fail_count++;
        end
        if (run_last !== want.last) begin
          $error("run_last mismatch: expected %0b, got %0b", want.last, run_last);
          fail_count++;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_item(logic signed [SAMPLE_BITS-1:0] s, logic e);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    sample   <= s;
    seq_end  <= e;
    do @(posedge clk); while (!in_ready);
    predict_fir(s, e);
    items_sent++;
    if (e) seqs_sent++;
  endtask

  // stop offering and wait for every expected item, then for the pipeline
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [COEF_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_TAP_COUNT) tap_cnt = data[TCNT_BITS-1:0];
    else coefs[idx - REG_COEF_0] = data;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all_coefs(logic [COEF_BITS-1:0] data);
    for (int k = 0; k < TAPS; k++) write_reg(IDX_BITS'(int'(REG_COEF_0) + k), data);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return '0;
      3:       return 16'hffff;
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  task automatic random_config();
    logic [COEF_BITS-1:0] data;
    // upper data bits of the tap count write are don't-care noise
    data = COEF_BITS'($urandom());
    data[TCNT_BITS-1:0] = TCNT_BITS'($urandom_range(7));
    write_reg(REG_TAP_COUNT, data);
    for (int k = 0; k < TAPS; k++) begin
      if ($urandom_range(1)) write_reg(IDX_BITS'(int'(REG_COEF_0) + k), rand_sample());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_defaults();
    send_item(16'sd5, 1'b0);
    send_item(-16'sd3, 1'b0);
    send_item(16'sd7, 1'b1);
    drain();
  endtask

  task automatic test_sum_extremes();
    write_reg(REG_TAP_COUNT, COEF_BITS'(TAP_COUNT_RESET));
    write_all_coefs(16'h8000);
    repeat (3) send_item(-16'sd32768, 1'b0);
    send_item(-16'sd32768, 1'b1);
    drain();
    write_all_coefs(16'h7fff);
    repeat (3) send_item(-16'sd32768, 1'b0);
    send_item(16'sd32767, 1'b1);
    drain();
  endtask

  task automatic test_short_taps();
    // one tap: run_last rides on the sample itself, no tail
    write_reg(REG_TAP_COUNT, 16'd1);
    send_item(16'sd1234, 1'b0);
    send_item(-16'sd99, 1'b1);
    drain();
    // zero taps behaves as one
    write_reg(REG_TAP_COUNT, 16'd0);
    send_item(16'sd321, 1'b1);
    drain();
  endtask

  task automatic test_midseq_reconfig();
    write_reg(REG_TAP_COUNT, 16'd5);
    write_reg(IDX_BITS'(int'(REG_COEF_0) + 1), 16'd2);
    send_item(16'sd10, 1'b0);
    send_item(16'sd20, 1'b0);
    send_item(-16'sd30, 1'b0);
    drain();
    // history stays full-depth, so widening the taps picks up old samples
    write_reg(REG_TAP_COUNT, 16'd7);
    write_reg(IDX_BITS'(int'(REG_COEF_0) + 3), -16'sd4);
    send_item(16'sd40, 1'b1);
    drain();
  endtask

  task automatic test_random_sequences(int n_items, int idle_pct, int stall_pct);
    int stop_at;
    int len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(2) == 0) begin
        drain();
        random_config();
      end
      len = ($urandom_range(7) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) send_item(rand_sample(), i == len - 1);
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_TAP_COUNT, 16'd7);
    write_all_coefs(16'sd3);
    hold_req++;
    for (int i = 0; i < 24; i++) send_item(rand_sample(), i == 23);
    drain();
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    sample         = '0;
    seq_end        = 1'b0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    fail_count     = 0;
    items_sent     = 0;
    results_checked = 0;
    seqs_sent      = 0;
    cfg_writes     = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    hold_ack       = 0;
    hold_left      = 0;
    tap_cnt        = TAP_COUNT_RESET;
    for (int i = 0; i < TAPS; i++) begin
      coefs[i]   = '0;
      history[i] = '0;
    end
    coefs[0]        = 16'sd1;
    coefs[TAPS - 1] = 16'sd1;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_sum_extremes();
    test_short_taps();
    test_midseq_reconfig();
    test_random_sequences(30, 0, 0);
    test_random_sequences(30, 62, 0);
    test_random_sequences(30, 0, 62);
    test_random_sequences(30, 9, 9);
    test_backpressure();

    drain();
    $display("Covered %0d items in %0d sequences, %0d results checked, %0d register writes",
             items_sent, seqs_sent, results_checked, cfg_writes);
    $display("Tap counts 0..7, extreme sums, mid-sequence changes, idling and long stall");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/fcs_pkg.sv
hdl/fcs_cell.sv
hdl/fcs_sum.sv
hdl/fir_convolution_stream.sv
sim/tb_top.sv
